FILE: sv/postfix_expression_evaluator_macros.svh
// ----------------------------------------------------------------------------
// postfix expression evaluator assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PFX_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("postfix evaluator assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("postfix evaluator assertion failed");

`endif

FILE: sv/pfx_eval_pkg.sv
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Types and fixed constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

    localparam int DATA_W = 32;
    localparam int ITER_W = 5;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_MUL,
        S_NEG_L,
        S_NEG_R,
        S_DIV,
        S_NEG_Q,
        S_FINISH
    } state_t;

    // result status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_BAD_SYMBOL  = 3'd1;
    localparam status_t ST_UNDERFLOW   = 3'd2;
    localparam status_t ST_OVERFLOW    = 3'd3;
    localparam status_t ST_COUNT       = 3'd4;
    localparam status_t ST_DIV_OR_LONG = 3'd5;

    // ascii symbols
    localparam logic [7:0] SYM_ZERO = 8'h30;
    localparam logic [7:0] SYM_NINE = 8'h39;
    localparam logic [7:0] SYM_ADD  = 8'h2B;
    localparam logic [7:0] SYM_SUB  = 8'h2D;
    localparam logic [7:0] SYM_MUL  = 8'h2A;
    localparam logic [7:0] SYM_DIV  = 8'h2F;

endpackage

FILE: sv/pfx_eval_ram.sv
// ----------------------------------------------------------------------------
// pfx_eval_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfx_eval_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rdata_reg;

endmodule

FILE: sv/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression taken one character per input word. Digits
// push a value, + - * / pop two values and push the 32-bit wrapped result,
// division truncating toward zero. The first error is latched, and the word
// flagged by s_tlast produces one output word holding the final value and a
// status, after which the stack is cleared. The stack lives in a RAM with the
// top entry kept in a register. One 32-bit adder is shared by every operation
// and iterates one bit per cycle for multiply and divide. s_tready is low while
// a word is being worked on. A final word waits in the last step until the
// output register is free. The stack RAM needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int MAX_LENGTH  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

    import pfx_eval_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);

    localparam logic [CNT_W-1:0]  CNT_DEPTH = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LENGTH);
    localparam logic [LEN_W-1:0]  LEN_ONE   = LEN_W'(1);
    localparam logic [ITER_W-1:0] ITER_LAST = {ITER_W{1'b1}};
    localparam logic [ITER_W-1:0] ITER_ONE  = ITER_W'(1);

    state_t state_reg, state_next;

    logic [7:0]        sym_reg, sym_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    status_t           err_reg, err_next;
    logic [DATA_W-1:0] opa_reg, opa_next;
    logic [DATA_W-1:0] opb_reg, opb_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              neg_reg, neg_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_value_reg, m_value_next;
    status_t           m_status_reg, m_status_next;

    logic [DATA_W-1:0] add_a, add_b;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              ram_we;
    logic [DATA_W-1:0] ram_rdata;

    logic              dec_digit, dec_op, op_go, out_free;
    logic [7:0]        digit_val;
    status_t           fin_status;
    logic              expr_cleared, result_step;

    // stack below the top entry
    pfx_eval_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_m1[ADDR_W-1:0]),
        .wr_data (top_reg),
        .rd_addr (cnt_m2[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // symbol decode and stack addresses
    assign cnt_m1    = cnt_reg - CNT_ONE;
    assign cnt_m2    = cnt_reg - CNT_TWO;
    assign digit_val = sym_reg - SYM_ZERO;
    assign dec_digit = (sym_reg >= SYM_ZERO) && (sym_reg <= SYM_NINE);
    assign dec_op    = (sym_reg == SYM_ADD) || (sym_reg == SYM_SUB) ||
                       (sym_reg == SYM_MUL) || (sym_reg == SYM_DIV);
    assign op_go     = (err_reg == ST_OK) && (len_reg < LEN_MAX) && dec_op &&
                       (cnt_reg >= CNT_TWO) &&
                       !((sym_reg == SYM_DIV) && (top_reg == '0));
    assign out_free  = !m_valid_reg || m_tready;

    // final status of the expression
    always_comb begin
        if (err_reg != ST_OK) begin
            fin_status = err_reg;
        end else if (cnt_reg != CNT_ONE) begin
            fin_status = ST_COUNT;
        end else begin
            fin_status = ST_OK;
        end
    end

    // shared adder operand select
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            S_LOAD: begin
                add_a   = ram_rdata;
                add_b   = top_reg;
                add_sub = (sym_reg == SYM_SUB);
            end
            S_MUL: begin
                add_a = acc_reg;
                add_b = opa_reg;
            end
            S_NEG_L: begin
                add_b   = opa_reg;
                add_sub = 1'b1;
            end
            S_NEG_R: begin
                add_b   = opb_reg;
                add_sub = 1'b1;
            end
            S_DIV: begin
                add_a   = {acc_reg[DATA_W-2:0], opa_reg[DATA_W-1]};
                add_b   = opb_reg;
                add_sub = 1'b1;
            end
            S_NEG_Q: begin
                add_b   = opa_reg;
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
    end

    // shared adder, carry out means no borrow when subtracting
    assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {DATA_W{add_sub}}} +
                     (DATA_W + 1)'(add_sub);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = op_go ? S_LOAD : S_FINISH;
            end
            S_LOAD: begin
                if (sym_reg == SYM_MUL) begin
                    state_next = S_MUL;
                end else if (sym_reg == SYM_DIV) begin
                    state_next = S_NEG_L;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_MUL: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = S_FINISH;
                end
            end
            S_NEG_L: begin
                state_next = S_NEG_R;
            end
            S_NEG_R: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (iter_reg == ITER_LAST) begin
                    state_next = S_NEG_Q;
                end
            end
            S_NEG_Q: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!last_reg || out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        sym_next      = sym_reg;
        last_next     = last_reg;
        top_next      = top_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        err_next      = err_reg;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        acc_next      = acc_reg;
        iter_next     = iter_reg;
        neg_next      = neg_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        ram_we        = 1'b0;
        s_tready      = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sym_next  = s_tdata;
                    last_next = s_tlast;
                end
            end
            S_DECODE: begin
                if (err_reg == ST_OK) begin
                    if (len_reg >= LEN_MAX) begin
                        err_next = ST_DIV_OR_LONG;
                    end else begin
                        len_next = len_reg + LEN_ONE;
                        if (dec_digit) begin
                            if (cnt_reg >= CNT_DEPTH) begin
                                err_next = ST_OVERFLOW;
                            end else begin
                                ram_we   = (cnt_reg != '0);
                                top_next = DATA_W'(digit_val);
                                cnt_next = cnt_reg + CNT_ONE;
                            end
                        end else if (dec_op) begin
                            if (cnt_reg < CNT_TWO) begin
                                err_next = ST_UNDERFLOW;
                            end else if ((sym_reg == SYM_DIV) && (top_reg == '0)) begin
                                err_next = ST_DIV_OR_LONG;
                            end
                        end else begin
                            err_next = ST_BAD_SYMBOL;
                        end
                    end
                end
            end
            S_LOAD: begin
                // left operand from ram, right operand is the top register
                acc_next  = '0;
                iter_next = '0;
                opa_next  = ram_rdata;
                opb_next  = top_reg;
                neg_next  = ram_rdata[DATA_W-1] ^ top_reg[DATA_W-1];
                if ((sym_reg == SYM_ADD) || (sym_reg == SYM_SUB)) begin
                    top_next = add_sum[DATA_W-1:0];
                    cnt_next = cnt_m1;
                end
            end
            S_MUL: begin
                // shift-add, one multiplier bit per cycle
                if (opb_reg[0]) begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                opa_next  = {opa_reg[DATA_W-2:0], 1'b0};
                opb_next  = {1'b0, opb_reg[DATA_W-1:1]};
                iter_next = iter_reg + ITER_ONE;
                if (iter_reg == ITER_LAST) begin
                    top_next = opb_reg[0] ? add_sum[DATA_W-1:0] : acc_reg;
                    cnt_next = cnt_m1;
                end
            end
            S_NEG_L: begin
                if (opa_reg[DATA_W-1]) begin
                    opa_next = add_sum[DATA_W-1:0];
                end
            end
            S_NEG_R: begin
                if (opb_reg[DATA_W-1]) begin
                    opb_next = add_sum[DATA_W-1:0];
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle
                acc_next  = add_sum[DATA_W] ? add_sum[DATA_W-1:0]
                                            : {acc_reg[DATA_W-2:0], opa_reg[DATA_W-1]};
                opa_next  = {opa_reg[DATA_W-2:0], add_sum[DATA_W]};
                iter_next = iter_reg + ITER_ONE;
            end
            S_NEG_Q: begin
                top_next = neg_reg ? add_sum[DATA_W-1:0] : opa_reg;
                cnt_next = cnt_m1;
            end
            S_FINISH: begin
                if (last_reg && out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = fin_status;
                    m_value_next  = (fin_status == ST_OK) ? top_reg : '0;
                    cnt_next      = '0;
                    len_next      = '0;
                    err_next      = ST_OK;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            len_reg     <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        top_reg      <= top_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        acc_reg      <= acc_next;
        iter_reg     <= iter_next;
        neg_reg      <= neg_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_status_reg, m_value_reg};

    // check terms
    assign expr_cleared = (cnt_reg == '0) && (len_reg == '0) && (err_reg == ST_OK);
    assign result_step  = (state_reg == S_FINISH) && last_reg;

    // checks
    `PFX_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_DEPTH)
    `PFX_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_MAX)
    `PFX_ASSERT_IMP(a_clear_on_result, aclk, aresetn, $rose(m_valid_reg), expr_cleared)
    `PFX_ASSERT_NEXT(a_err_held, aclk, aresetn, (err_reg != ST_OK) && !result_step, $stable(err_reg))

endmodule
